// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Payload structs, register indexes and fixed coefficients of the barometric
// pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DIV_W      = 32;
    localparam int DIV_STAGES = DIV_W;
    localparam int UP_W       = 19;

    localparam logic [31:0] C_B6_OFS = 32'd4000;
    localparam logic [31:0] C_X1_MUL = 32'd3038;
    localparam logic [31:0] C_X2_MUL = 32'hFFFF_E343;
    localparam logic [31:0] C_P_OFS  = 32'd3791;
    localparam logic [31:0] C_B7_MUL = 32'd50000;
    localparam logic [31:0] C_B4_OFS = 32'd32768;

    typedef enum logic [1:0] {
        REG_OSS     = 2'd0,
        REG_COEFF_A = 2'd1,
        REG_COEFF_B = 2'd2,
        REG_COEFF_C = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [7:0]  pressure_msb;
        logic [7:0]  pressure_lsb;
        logic [7:0]  pressure_xlsb;
    } t_in;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               div_error;
    } t_out;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

// ===== hdl/bpc_udiv.sv =====
// ----------------------------------------------------------------------------
// bpc_udiv: pipelined unsigned divider
// Restoring division, one quotient bit per stage, all stages advance on i_en.
// ----------------------------------------------------------------------------
module bpc_udiv (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bpc_pkg::DIV_W-1:0]  i_num,
    input  logic [bpc_pkg::DIV_W-1:0]  i_den,
    output logic [bpc_pkg::DIV_W-1:0]  o_quo
);
    localparam int W = bpc_pkg::DIV_W;
    localparam int N = bpc_pkg::DIV_STAGES;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_qn  [N];
    logic [W-1:0] r_den [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [W-1:0] s_rem, s_qn, s_den;
        logic [W:0]   s_trial;
        logic [W:0]   s_diff;
        logic [W-1:0] n_rem, n_qn;

        if (k == 0) begin : g_first
            assign s_rem = '0;
            assign s_qn  = i_num;
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_qn  = r_qn[k-1];
            assign s_den = r_den[k-1];
        end

        always_comb begin
            s_trial = {s_rem, s_qn[W-1]};
            s_diff  = s_trial - {1'b0, s_den};
            if (!s_diff[W]) begin
                n_rem = s_diff[W-1:0];
                n_qn  = {s_qn[W-2:0], 1'b1};
            end else begin
                n_rem = s_trial[W-1:0];
                n_qn  = {s_qn[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_qn[k]  <= n_qn;
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quo = r_qn[N-1];

endmodule

// ===== hdl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation: integer temperature/pressure compensation
// Pipelined datapath from raw readings and calibration words to temperature
// in tenths of a degree and pressure in pascals.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_in_data  (bpc_pkg::t_in)
//  out     | source    | o_out_valid/i_out_stall | o_out_data (bpc_pkg::t_out)
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One transfer per cycle sustained while the output is not stalled. The
//  pipeline has 14 + 2 x 32 = 78 register stages, most of them in the two
//  32-stage dividers (temperature divisor, pressure divisor B4).
//  i_rst_n (synchronous) clears all valid bits and loads oversampling 3.
//  A stalled output freezes the whole pipeline and raises o_in_stall; no
//  transfer is lost or repeated. The cfg port always accepts.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bpc_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bpc_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);
    localparam int N = bpc_pkg::DIV_STAGES;

    // ---------------- configuration ----------------
    logic [1:0]  r_os;
    logic [63:0] r_ca, r_cb;
    logic [31:0] r_cc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_os <= 2'd3;
            r_ca <= '0;
            r_cb <= '0;
            r_cc <= '0;
        end else if (i_cfg_valid) begin
            unique case (bpc_pkg::t_reg_idx'(i_cfg_index))
                bpc_pkg::REG_OSS:     r_os <= i_cfg_data[1:0];
                bpc_pkg::REG_COEFF_A: r_ca <= i_cfg_data;
                bpc_pkg::REG_COEFF_B: r_cb <= i_cfg_data;
                bpc_pkg::REG_COEFF_C: r_cc <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Coefficients are read live; the user must keep them stable while items are in flight; the block does not check.
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bpc_pkg::sx16(r_ca[15:0]);
    assign ac2 = bpc_pkg::sx16(r_ca[31:16]);
    assign ac3 = bpc_pkg::sx16(r_ca[47:32]);
    assign ac4 = {16'd0, r_ca[63:48]};
    assign ac5 = {16'd0, r_cb[15:0]};
    assign ac6 = {16'd0, r_cb[31:16]};
    assign b1  = bpc_pkg::sx16(r_cb[47:32]);
    assign b2  = bpc_pkg::sx16(r_cb[63:48]);
    assign mc  = bpc_pkg::sx16(r_cc[15:0]);
    assign md  = bpc_pkg::sx16(r_cc[31:16]);

    // ---------------- flow control ----------------
    // Advance everything unless a finished result is held by the sink.
    logic en;
    logic r_o_v;
    assign en          = !(r_o_v && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_o_v;

    // ---------------- valid chain ----------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;
    logic r11_v, r12_v, r13_v;
    logic d1_v [N];
    logic d2_v [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v} <= '0;
            {r8_v, r9_v, r10_v, r11_v, r12_v, r13_v, r_o_v} <= '0;
            for (int k = 0; k < N; k++) begin
                d1_v[k] <= 1'b0;
                d2_v[k] <= 1'b0;
            end
        end else if (en) begin
            r1_v  <= i_in_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            d1_v[0] <= r3_v;
            for (int k = 1; k < N; k++) begin
                d1_v[k] <= d1_v[k-1];
                d2_v[k] <= d2_v[k-1];
            end
            r4_v  <= d1_v[N-1];
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            d2_v[0] <= r10_v;
            r11_v <= d2_v[N-1];
            r12_v <= r11_v;
            r13_v <= r12_v;
            r_o_v <= r13_v;
        end
    end

    // ---------------- stage 1: capture, assemble UP ----------------
    logic [15:0] r1_ut;
    logic [bpc_pkg::UP_W-1:0] r1_up;

    // ---------------- stage 2: (UT - AC6) * AC5 ----------------
    logic [31:0] r2_prod;
    logic [bpc_pkg::UP_W-1:0] r2_up;

    // ---------------- stage 3: divider 1 operands ----------------
    logic [31:0] s3_x1, s3_den, s3_num;
    logic [31:0] r3_num, r3_den, r3_x1;
    logic        r3_err, r3_neg;
    logic [bpc_pkg::UP_W-1:0] r3_up;

    assign s3_x1  = bpc_pkg::asr(r2_prod, 15);
    assign s3_den = s3_x1 + md;
    assign s3_num = mc << 11;

    // divider 1 side line
    logic [31:0] d1_x1  [N];
    logic        d1_err [N];
    logic        d1_neg [N];
    logic [bpc_pkg::UP_W-1:0] d1_up [N];
    logic [31:0] q1;

    bpc_udiv u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r3_num),
        .i_den (r3_den),
        .o_quo (q1)
    );

    // ---------------- stage 4: B5, B6 ----------------
    logic [31:0] s4_x2, s4_b5;
    logic [31:0] r4_b5, r4_b6;
    logic        r4_err;
    logic [bpc_pkg::UP_W-1:0] r4_up;

    assign s4_x2 = d1_neg[N-1] ? 32'd0 - q1 : q1;
    assign s4_b5 = d1_x1[N-1] + s4_x2;

    // ---------------- stage 5: products of B6, temperature ----------------
    logic [31:0] s5_t;
    logic [15:0] s5_temp;
    logic [31:0] r5_sqp, r5_a2, r5_a3;
    logic [15:0] r5_temp;
    logic        r5_err;
    logic [bpc_pkg::UP_W-1:0] r5_up;

    always_comb begin
        s5_t = bpc_pkg::asr(r4_b5 + 32'd8, 4);
        if ($signed(s5_t) > 32'sd32767) begin
            s5_temp = 16'h7FFF;
        end else if ($signed(s5_t) < -32'sd32768) begin
            s5_temp = 16'h8000;
        end else begin
            s5_temp = s5_t[15:0];
        end
    end

    // ---------------- stage 6: scale ----------------
    logic [31:0] r6_sq, r6_x2a, r6_x1c;
    logic [15:0] r6_temp;
    logic        r6_err;
    logic [bpc_pkg::UP_W-1:0] r6_up;

    // ---------------- stage 7: B2*SQ, B1*SQ ----------------
    logic [31:0] r7_b2sq, r7_b1sq, r7_x2a, r7_x1c;
    logic [15:0] r7_temp;
    logic        r7_err;
    logic [bpc_pkg::UP_W-1:0] r7_up;

    // ---------------- stage 8: B3 and X3 ----------------
    logic [31:0] s8_x3, s8_tt, s8_b3, s8_x3b;
    logic [31:0] r8_b3, r8_x3b;
    logic [15:0] r8_temp;
    logic        r8_err;
    logic [bpc_pkg::UP_W-1:0] r8_up;

    always_comb begin
        s8_x3  = bpc_pkg::asr(r7_b2sq, 11) + r7_x2a;
        s8_tt  = (((ac1 << 2) + s8_x3) << r_os) + 32'd2;
        // signed divide by four, truncating toward zero
        s8_b3  = bpc_pkg::asr(s8_tt + (s8_tt[31] ? 32'd3 : 32'd0), 2);
        s8_x3b = bpc_pkg::asr(r7_x1c + bpc_pkg::asr(r7_b1sq, 16) + 32'd2, 2);
    end

    // ---------------- stage 9: AC4 product, B7 ----------------
    logic [31:0] r9_m, r9_b7;
    logic [15:0] r9_temp;
    logic        r9_err;

    // ---------------- stage 10: B4, divider 2 operands ----------------
    logic [16:0] s10_b4;
    logic [31:0] r10_num;
    logic [16:0] r10_b4;
    logic        r10_err, r10_dbl;
    logic [15:0] r10_temp;

    assign s10_b4 = r9_m[31:15];

    logic        d2_err  [N];
    logic        d2_dbl  [N];
    logic [15:0] d2_temp [N];
    logic [31:0] q2;

    bpc_udiv u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r10_num),
        .i_den ({15'd0, r10_b4}),
        .o_quo (q2)
    );

    // ---------------- stages 11..13 and output ----------------
    logic [31:0] r11_p, r12_p, r12_m1, r12_m2, r13_p, r13_m3, r13_x2;
    logic [15:0] r11_temp, r12_temp, r13_temp;
    logic        r11_err, r12_err, r13_err;
    logic [31:0] s11_p8, s14_p;
    bpc_pkg::t_out r_out;

    assign s11_p8 = bpc_pkg::asr(r11_p, 8);
    assign s14_p  = r13_p + bpc_pkg::asr(bpc_pkg::asr(r13_m3, 16) + r13_x2
                                         + bpc_pkg::C_P_OFS, 4);

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_ut <= i_in_data.raw_temperature;
            r1_up <= bpc_pkg::UP_W'({i_in_data.pressure_msb, i_in_data.pressure_lsb,
                     i_in_data.pressure_xlsb} >> (4'd8 - {2'd0, r_os}));
            // stage 2
            r2_prod <= ({16'd0, r1_ut} - ac6) * ac5;
            r2_up   <= r1_up;
            // stage 3: split signs for the unsigned divider
            r3_err <= (s3_den == 32'd0);
            r3_neg <= s3_num[31] ^ s3_den[31];
            r3_num <= s3_num[31] ? 32'd0 - s3_num : s3_num;
            r3_den <= s3_den[31] ? 32'd0 - s3_den : s3_den;
            r3_x1  <= s3_x1;
            r3_up  <= r2_up;
            // divider 1 side line
            d1_x1[0]  <= r3_x1;
            d1_err[0] <= r3_err;
            d1_neg[0] <= r3_neg;
            d1_up[0]  <= r3_up;
            for (int k = 1; k < N; k++) begin
                d1_x1[k]  <= d1_x1[k-1];
                d1_err[k] <= d1_err[k-1];
                d1_neg[k] <= d1_neg[k-1];
                d1_up[k]  <= d1_up[k-1];
            end
            // stage 4
            r4_b5  <= s4_b5;
            r4_b6  <= s4_b5 - bpc_pkg::C_B6_OFS;
            r4_err <= d1_err[N-1];
            r4_up  <= d1_up[N-1];
            // stage 5
            r5_sqp  <= r4_b6 * r4_b6;
            r5_a2   <= ac2 * r4_b6;
            r5_a3   <= ac3 * r4_b6;
            r5_temp <= s5_temp;
            r5_err  <= r4_err;
            r5_up   <= r4_up;
            // stage 6
            r6_sq   <= bpc_pkg::asr(r5_sqp, 12);
            r6_x2a  <= bpc_pkg::asr(r5_a2, 11);
            r6_x1c  <= bpc_pkg::asr(r5_a3, 13);
            r6_temp <= r5_temp;
            r6_err  <= r5_err;
            r6_up   <= r5_up;
            // stage 7
            r7_b2sq <= b2 * r6_sq;
            r7_b1sq <= b1 * r6_sq;
            r7_x2a  <= r6_x2a;
            r7_x1c  <= r6_x1c;
            r7_temp <= r6_temp;
            r7_err  <= r6_err;
            r7_up   <= r6_up;
            // stage 8
            r8_b3   <= s8_b3;
            r8_x3b  <= s8_x3b;
            r8_temp <= r7_temp;
            r8_err  <= r7_err;
            r8_up   <= r7_up;
            // stage 9
            r9_m    <= ac4 * (r8_x3b + bpc_pkg::C_B4_OFS);
            r9_b7   <= ({13'd0, r8_up} - r8_b3) * (bpc_pkg::C_B7_MUL >> r_os);
            r9_temp <= r8_temp;
            r9_err  <= r8_err;
            // stage 10: double before dividing unless B7 would overflow
            r10_b4   <= s10_b4;
            r10_err  <= r9_err || (s10_b4 == 17'd0);
            r10_dbl  <= r9_b7[31];
            r10_num  <= r9_b7[31] ? r9_b7 : {r9_b7[30:0], 1'b0};
            r10_temp <= r9_temp;
            // divider 2 side line
            d2_err[0]  <= r10_err;
            d2_dbl[0]  <= r10_dbl;
            d2_temp[0] <= r10_temp;
            for (int k = 1; k < N; k++) begin
                d2_err[k]  <= d2_err[k-1];
                d2_dbl[k]  <= d2_dbl[k-1];
                d2_temp[k] <= d2_temp[k-1];
            end
            // stage 11
            r11_p    <= d2_dbl[N-1] ? {q2[30:0], 1'b0} : q2;
            r11_err  <= d2_err[N-1];
            r11_temp <= d2_temp[N-1];
            // stage 12
            r12_m1   <= s11_p8 * s11_p8;
            r12_m2   <= bpc_pkg::C_X2_MUL * r11_p;
            r12_p    <= r11_p;
            r12_err  <= r11_err;
            r12_temp <= r11_temp;
            // stage 13
            r13_m3   <= r12_m1 * bpc_pkg::C_X1_MUL;
            r13_x2   <= bpc_pkg::asr(r12_m2, 16);
            r13_p    <= r12_p;
            r13_err  <= r12_err;
            r13_temp <= r12_temp;
            // output register: zero the results on a divide error
            r_out.div_error          <= r13_err;
            r_out.temperature_tenths <= r13_err ? 16'sd0 : $signed(r13_temp);
            r_out.pressure_pa        <= r13_err ? 32'sd0 : $signed(s14_p);
        end
    end

    assign o_out_data = r_out;

endmodule
